### sv/rssi_bin_survey_accumulator_unit_defines.svh
// Assertion macros used by the survey accumulator datapath.
`ifndef RSSI_BIN_SURVEY_ACCUMULATOR_UNIT_DEFINES_SVH
`define RSSI_BIN_SURVEY_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RBSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rbsa_pkg.sv
// Types and constants of the signal-strength bin survey accumulator.
package rbsa_pkg;

  localparam int BIN_COUNT = 64;
  localparam int BIN_AW    = $clog2(BIN_COUNT);
  localparam int REP_W     = $clog2(BIN_COUNT + 1);
  localparam int DIV_STEPS = 28;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  localparam logic [REP_W-1:0] NO_BIN = REP_W'(BIN_COUNT);
  localparam logic [15:0] LIMIT_RESET = 16'd60000;
  localparam logic [15:0] DROP_MAX    = 16'hFFFF;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_PLAIN, S_RD, S_CHK, S_DIV, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OUT_ZERO, OUT_ADD, OUT_REP
  } out_src_t;

  typedef struct packed {
    logic signed [27:0] sum;
    logic [15:0]        cnt;
    logic signed [11:0] low;
    logic signed [11:0] peak;
    logic [15:0]        drop;
  } bin_entry_t;

  // Result item, highest field first so that the last field lands in bit 0.
  typedef struct packed {
    logic [5:0]         pad;
    logic [6:0]         sampled_bins;
    logic [6:0]         loudest;
    logic [6:0]         quietest;
    logic [15:0]        bin_dropped_out;
    logic signed [11:0] bin_peak_out;
    logic signed [11:0] bin_low_out;
    logic signed [27:0] bin_sum_out;
    logic [15:0]        bin_count_out;
    logic               sample_taken;
  } out_item_t;

  typedef struct packed {
    logic     take;
    logic     rd_en;
    logic     rd_from_in;
    logic     do_add;
    logic     do_clear;
    logic     idx_inc;
    logic     div_start;
    logic     rep_peak;
    logic     rep_mean;
    logic     load_out;
    out_src_t out_src;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [1:0] func;
    logic       nonempty;
    logic       last_idx;
    logic       div_done;
  } stat_t;

endpackage

### sv/rbsa_div.sv
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle.
module rbsa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [27:0] dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic signed [28:0] quotient
);
  import rbsa_pkg::*;

  logic              run_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [15:0]       rem_r;
  logic [27:0]       quo_r;
  logic              neg_r;
  logic [27:0]       mag;
  logic [16:0]       trial;
  logic              ge;
  logic [15:0]       rem_nxt;

  assign mag     = dividend[27] ? 28'(-dividend) : 28'(dividend);
  assign trial   = {rem_r, quo_r[27]};
  assign ge      = trial >= {1'b0, divisor};
  assign rem_nxt = ge ? 16'(trial - {1'b0, divisor}) : 16'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CW'(DIV_STEPS);
        quo_r <= mag;
        rem_r <= '0;
        neg_r <= dividend[27];
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[26:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

### sv/rbsa_datapath.sv
// Bin store, update logic, report scan registers and result register.
module rbsa_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rbsa_pkg::cmd_t          cmd,
  output rbsa_pkg::stat_t         stat,
  input  logic [1:0]              in_func,
  input  logic [5:0]              in_bin,
  input  logic signed [11:0]      in_rssi,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_wdata,
  input  logic                    out_ready,
  output logic                    out_valid,
  output rbsa_pkg::out_item_t     out_item
);
  import rbsa_pkg::*;
  `include "rssi_bin_survey_accumulator_unit_defines.svh"

  bin_entry_t         mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] vld_r;
  logic [15:0]        limit_r;

  logic [1:0]         func_r;
  logic [BIN_AW-1:0]  bin_r;
  logic               bin_ok_r;
  logic signed [11:0] rssi_r;

  bin_entry_t         rd_q;
  logic               rd_v_r;
  logic [BIN_AW-1:0]  rd_addr;

  logic [BIN_AW-1:0]  idx_r;
  logic [REP_W-1:0]   n_r, q_r, l_r;
  logic signed [28:0] qm_r;
  logic signed [11:0] lp_r;

  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  logic               div_done;
  logic signed [28:0] div_q;

  bin_entry_t         cur, upd;
  logic               add_taken;
  logic               wr_en;

  assign rd_addr = cmd.rd_from_in ? BIN_AW'(in_bin) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_RESET;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r   <= in_func;
      bin_r    <= BIN_AW'(in_bin);
      bin_ok_r <= 32'(in_bin) < BIN_COUNT;
      rssi_r   <= in_rssi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_v_r <= vld_r[rd_addr];
    end
    if (wr_en) mem[bin_r] <= upd;
  end

  // Valid bits stand in for the zero reset value of every bin.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.do_clear) vld_r <= '0;
    else if (wr_en) vld_r[bin_r] <= 1'b1;
  end

  always_comb begin
    cur      = rd_q;
    if (!rd_v_r) begin
      cur.sum  = '0;
      cur.cnt  = '0;
      cur.drop = '0;
    end
    upd       = cur;
    add_taken = 1'b0;
    if (cur.cnt >= limit_r) begin
      if (cur.drop != DROP_MAX) upd.drop = cur.drop + 16'd1;
    end else begin
      add_taken = 1'b1;
      if (cur.cnt == 16'd0) begin
        upd.low  = rssi_r;
        upd.peak = rssi_r;
      end else begin
        if (rssi_r < cur.low)  upd.low  = rssi_r;
        if (rssi_r > cur.peak) upd.peak = rssi_r;
      end
      upd.cnt = cur.cnt + 16'd1;
      upd.sum = cur.sum + 28'(rssi_r);
    end
  end

  assign wr_en = cmd.do_add && bin_ok_r;

  rbsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_q.sum),
    .divisor  (rd_q.cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      q_r <= NO_BIN;
      l_r <= NO_BIN;
    end else if (cmd.take) begin
      idx_r <= '0;
      n_r   <= '0;
      q_r   <= NO_BIN;
      l_r   <= NO_BIN;
    end else begin
      if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.rep_peak) begin
        n_r <= n_r + 1'b1;
        if (l_r == NO_BIN || rd_q.peak > lp_r) begin
          l_r  <= REP_W'(idx_r);
          lp_r <= rd_q.peak;
        end
      end
      if (cmd.rep_mean && (q_r == NO_BIN || div_q < qm_r)) begin
        q_r  <= REP_W'(idx_r);
        qm_r <= div_q;
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    case (cmd.out_src)
      OUT_ADD: begin
        if (bin_ok_r) begin
          out_nxt.sample_taken    = add_taken;
          out_nxt.bin_count_out   = upd.cnt;
          out_nxt.bin_sum_out     = upd.sum;
          out_nxt.bin_dropped_out = upd.drop;
          if (upd.cnt != 16'd0) begin
            out_nxt.bin_low_out  = upd.low;
            out_nxt.bin_peak_out = upd.peak;
          end
        end
      end
      OUT_REP: begin
        out_nxt.quietest     = 7'(q_r);
        out_nxt.loudest      = 7'(l_r);
        out_nxt.sampled_bins = 7'(n_r);
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_r;
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.func     = func_r;
  assign stat.nonempty = rd_v_r && (rd_q.cnt != 16'd0);
  assign stat.last_idx = idx_r == BIN_AW'(BIN_COUNT - 1);
  assign stat.div_done = div_done;

  `RBSA_ASSERT_NEXT(a_div_not_instant, cmd.div_start, !div_done, "divider finished at once")
  `RBSA_ASSERT_NOW(a_empty_scan, n_r == '0, q_r == NO_BIN && l_r == NO_BIN, "bin chosen with none counted")
  `RBSA_ASSERT_NOW(a_taken_count, cmd.load_out && cmd.out_src == OUT_ADD && add_taken, upd.cnt != 16'd0, "stored sample left count at zero")

endmodule

### sv/rbsa_ctrl.sv
// Sequencer for add, clear and report requests.
module rbsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  output logic             in_ready,
  input  rbsa_pkg::stat_t  stat,
  output rbsa_pkg::cmd_t   cmd
);
  import rbsa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_src = OUT_ZERO;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take       = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.rd_from_in = 1'b1;
          case (in_func)
            FUNC_ADD:    state_nxt = S_ADD;
            FUNC_REPORT: state_nxt = S_RD;
            default:     state_nxt = S_PLAIN;
          endcase
        end
      end
      S_ADD: begin
        if (stat.out_free) begin
          cmd.do_add   = 1'b1;
          cmd.load_out = 1'b1;
          cmd.out_src  = OUT_ADD;
          state_nxt    = S_IDLE;
        end
      end
      S_PLAIN: begin
        if (stat.out_free) begin
          cmd.do_clear = stat.func == FUNC_CLEAR;
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.nonempty) begin
          cmd.rep_peak  = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (stat.last_idx) begin
          state_nxt = S_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.rep_mean = 1'b1;
          if (stat.last_idx) begin
            state_nxt = S_OUT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_src  = OUT_REP;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### sv/rssi_bin_survey_accumulator_unit.sv
// Top level of the signal-strength bin survey accumulator.
// Each request gives one result. An add reads the bin store in the accept
// cycle and writes it back in the add state once the result register is free;
// a clear empties all bins once it is free. A report walks all 64 bins: each
// bin is read and checked, and for a non-empty bin the bit-serial divider
// forms the mean at one quotient bit per cycle; the result is loaded once the
// result register is free. A new request is taken once the previous one has
// been handed to the result register, which holds it until downstream takes it.
module rssi_bin_survey_accumulator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // bin_sel[5:0], rssi_sample[17:6], zero pad
  input  logic [1:0]   in_tuser,   // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // sample_taken[0], bin_count_out[16:1],
                                   // bin_sum_out[44:17], bin_low_out[56:45],
                                   // bin_peak_out[68:57], bin_dropped_out[84:69],
                                   // quietest[91:85], loudest[98:92],
                                   // sampled_bins[105:99], zero pad
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import rbsa_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  out_item_t out_item;

  rbsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbsa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (in_tuser),
    .in_bin    (in_tdata[5:0]),
    .in_rssi   ($signed(in_tdata[17:6])),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (out_item)
  );

  assign out_tdata = 112'(out_item);

endmodule

### dv/testbench.sv
// Self-checking testbench for the signal-strength bin survey accumulator.
module testbench;
  import rbsa_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 10000000;
  localparam int         HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]         func;
    logic [5:0]         bin;
    logic signed [11:0] rssi;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  rssi_bin_survey_accumulator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  request_t  pending_requests[$];
  out_item_t expected_results[$];

  // Shadow copy of the bin statistics.
  int          bin_sum[BIN_COUNT];
  int unsigned bin_cnt[BIN_COUNT];
  int          bin_low[BIN_COUNT];
  int          bin_peak[BIN_COUNT];
  int unsigned bin_drop[BIN_COUNT];
  int unsigned limit_shadow = LIMIT_RESET;

  int errors = 0;
  int n_add = 0, n_drop = 0, n_report = 0, n_clear = 0, n_results = 0;
  int cycles = 0;
  int src_idle = 0, rcv_idle = 0;
  int phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit just_taken = 1'b0;

  function automatic void clear_survey();
    for (int i = 0; i < BIN_COUNT; i++) begin
      bin_sum[i] = 0; bin_cnt[i] = 0; bin_low[i] = 0; bin_peak[i] = 0; bin_drop[i] = 0;
    end
  endfunction

  function automatic out_item_t survey_step(request_t r);
    out_item_t res;
    int n, q, l, qm, lp, m;
    res = '0;
    case (r.func)
      FUNC_ADD: begin
        n_add++;
        if (bin_cnt[r.bin] >= limit_shadow) begin
          n_drop++;
          if (bin_drop[r.bin] < DROP_MAX) bin_drop[r.bin]++;
        end else begin
          if (bin_cnt[r.bin] == 0) begin
            bin_low[r.bin] = r.rssi;
            bin_peak[r.bin] = r.rssi;
          end else begin
            if (r.rssi < bin_low[r.bin]) bin_low[r.bin] = r.rssi;
            if (r.rssi > bin_peak[r.bin]) bin_peak[r.bin] = r.rssi;
          end
          bin_cnt[r.bin]++;
          bin_sum[r.bin] += r.rssi;
          res.sample_taken = 1'b1;
        end
        res.bin_count_out = 16'(bin_cnt[r.bin]);
        res.bin_sum_out = 28'(bin_sum[r.bin]);
        if (bin_cnt[r.bin] != 0) begin
          res.bin_low_out = 12'(bin_low[r.bin]);
          res.bin_peak_out = 12'(bin_peak[r.bin]);
        end
        res.bin_dropped_out = 16'(bin_drop[r.bin]);
      end
      FUNC_CLEAR: begin
        n_clear++;
        clear_survey();
      end
      FUNC_REPORT: begin
        n_report++;
        n = 0; q = BIN_COUNT; l = BIN_COUNT; qm = 0; lp = 0;
        for (int i = 0; i < BIN_COUNT; i++) begin
          if (bin_cnt[i] != 0) begin
            n++;
            m = bin_sum[i] / int'(bin_cnt[i]);  // truncates toward zero
            if (q == BIN_COUNT || m < qm) begin q = i; qm = m; end
            if (l == BIN_COUNT || bin_peak[i] > lp) begin l = i; lp = bin_peak[i]; end
          end
        end
        res.quietest = 7'(q);
        res.loudest = 7'(l);
        res.sampled_bins = 7'(n);
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch at cycle %0d in %s: got %0d, expected %0d", cycles, field, got, want);
  endtask

  // Request acceptance, prediction and result checking share one edge process.
  always @(posedge clk) begin
    out_item_t got, want;
    cycles <= cycles + 1;
    if (cfg_we) limit_shadow = cfg_wdata;
    just_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(survey_step(pending_requests[0]));
      void'(pending_requests.pop_front());
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_item_t'(out_tdata);
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("result count", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.sample_taken !== want.sample_taken)
          report_mismatch("sample_taken", got.sample_taken, want.sample_taken);
        if (got.bin_count_out !== want.bin_count_out)
          report_mismatch("bin_count_out", got.bin_count_out, want.bin_count_out);
        if (got.bin_sum_out !== want.bin_sum_out)
          report_mismatch("bin_sum_out", got.bin_sum_out, want.bin_sum_out);
        if (got.bin_low_out !== want.bin_low_out)
          report_mismatch("bin_low_out", got.bin_low_out, want.bin_low_out);
        if (got.bin_peak_out !== want.bin_peak_out)
          report_mismatch("bin_peak_out", got.bin_peak_out, want.bin_peak_out);
        if (got.bin_dropped_out !== want.bin_dropped_out)
          report_mismatch("bin_dropped_out", got.bin_dropped_out, want.bin_dropped_out);
        if (got.quietest !== want.quietest)
          report_mismatch("quietest", got.quietest, want.quietest);
        if (got.loudest !== want.loudest)
          report_mismatch("loudest", got.loudest, want.loudest);
        if (got.sampled_bins !== want.sampled_bins)
          report_mismatch("sampled_bins", got.sampled_bins, want.sampled_bins);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sender: an offered request is held until it is taken.
  always @(negedge clk) begin
    logic offer;
    offer = in_tvalid && !just_taken;
    if (rst_n && !offer && pending_requests.size() > 0)
      offer = $urandom_range(99) >= src_idle;
    if (offer && pending_requests.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tuser <= pending_requests[0].func;
      in_tdata <= {6'b0, pending_requests[0].rssi, pending_requests[0].bin};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver, including one long hold-off so that the block backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (phase == 3 && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic queue_request(logic [1:0] func, int bin, int rssi);
    request_t r;
    r.func = func;
    r.bin = 6'(bin);
    r.rssi = 12'(rssi);
    pending_requests.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_results.size() != 0 || in_tvalid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int count, int hot_bins);
    int sel;
    int rssi;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      rssi = $urandom_range(9) == 0 ? ($urandom_range(1) ? 2047 : -2048)
                                    : int'($urandom_range(4095)) - 2048;
      if (sel < 4) queue_request(FUNC_REPORT, 0, 0);
      else if (sel < 6) queue_request(FUNC_CLEAR, $urandom_range(63), rssi);
      else if (sel < 8) queue_request(FUNC_UNUSED, $urandom_range(63), rssi);
      else if (sel < 70) queue_request(FUNC_ADD, $urandom_range(hot_bins - 1), rssi);
      else queue_request(FUNC_ADD, $urandom_range(63), rssi);
    end
  endtask

  initial begin
    clear_survey();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty survey, ties on mean and peak, extremes, truncation of negative means.
    queue_request(FUNC_REPORT, 0, 0);
    queue_request(FUNC_ADD, 5, 100);
    queue_request(FUNC_ADD, 9, 100);
    queue_request(FUNC_REPORT, 0, 0);
    queue_request(FUNC_ADD, 63, 2047);
    queue_request(FUNC_ADD, 0, -2048);
    queue_request(FUNC_ADD, 0, -1);
    queue_request(FUNC_ADD, 1, -3);
    queue_request(FUNC_ADD, 1, 0);
    queue_request(FUNC_REPORT, 0, 0);
    queue_request(FUNC_UNUSED, 63, -1);
    queue_request(FUNC_CLEAR, 0, 0);
    queue_request(FUNC_REPORT, 0, 0);
    wait_drained();
    write_limit(16'd1);
    queue_request(FUNC_ADD, 2, -2048);
    queue_request(FUNC_ADD, 2, 2047);
    queue_request(FUNC_ADD, 2, 0);
    queue_request(FUNC_ADD, 62, 2047);
    queue_request(FUNC_REPORT, 0, 0);
    wait_drained();

    write_limit(16'd4);
    src_idle = 20; rcv_idle = 77; phase = 1;
    queue_random(220, 6);
    wait_drained();

    write_limit(16'hFFFF);
    src_idle = 77; rcv_idle = 20; phase = 2;
    queue_random(220, 8);
    wait_drained();

    write_limit(16'd2);
    src_idle = 0; rcv_idle = 0; phase = 3;
    queue_random(210, 12);
    wait_drained();
    repeat (50) @(negedge clk);

    $display("covered %0d adds (%0d dropped), %0d reports, %0d clears, %0d results checked",
             n_add, n_drop, n_report, n_clear, n_results);
    $display("sample limits 1, 2, 4, 65535 and the reset value, with stalls on both sides");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/rbsa_pkg.sv
sv/rbsa_div.sv
sv/rbsa_datapath.sv
sv/rbsa_ctrl.sv
sv/rssi_bin_survey_accumulator_unit.sv
dv/testbench.sv
